[rtl/core/dasp_pkg.sv]
// dual-axis servo pid: shared widths, default constants, codes and interface structs
// no dependencies; imported by every module of the block
package dasp_pkg;

    localparam int ENC_W      = 16;
    localparam int POS_W      = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int GAIN_W     = 16;
    localparam int CNT_W      = 16;
    localparam int DUTY_W     = 13;
    localparam int QOUT_W     = 18;
    localparam int SUM_W      = GAIN_W + 1 + DIFF_W + 2;
    localparam int LANE_DEPTH = 5;
    localparam int CFG_IDX_W  = 3;

    localparam int PWM_MAX_DEF        = 4199;
    localparam int INTEGRAL_LIMIT_DEF = 5000;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd32000;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd384;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd192;
    localparam logic [CNT_W-1:0]  MAX_FOLLOW_RST = 16'd300;
    localparam logic [CNT_W-1:0]  MAX_TICKS_RST  = 16'd500;

    typedef enum logic [1:0] {
        FUNC_STEP_X = 2'd0,
        FUNC_STEP_Y = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_X    = 3'd0,
        CFG_INTEG_X   = 3'd1,
        CFG_DERIV_X   = 3'd2,
        CFG_PROP_Y    = 3'd3,
        CFG_INTEG_Y   = 3'd4,
        CFG_DERIV_Y   = 3'd5,
        CFG_MAX_FOLLOW = 3'd6,
        CFG_MAX_TICKS = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
    } gains_t;

    typedef struct packed {
        logic [CNT_W-1:0] max_follow_error;
        logic [CNT_W-1:0] max_error_ticks;
    } limits_t;

    typedef struct packed {
        logic valid;
        logic fault;
    } tick_ctl_t;

    // signed width that holds +/-limit
    function automatic int acc_width(input int limit);
        return $clog2(limit + 1) + 1;
    endfunction

endpackage

[rtl/core/dasp_lane.sv]
// one axis pid lane: integrator, derivative, following-error counter, gain products,
// sum, q8.8 truncation toward zero and output clamp; depends on dasp_pkg
module dasp_lane
    import dasp_pkg::*;
#(
    parameter int PWM_MAX        = PWM_MAX_DEF,
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     go,
    input  logic signed [POS_W-1:0]  e_in,
    input  gains_t                   gains,
    input  limits_t                  limits,
    output logic                     alarm_set,
    output logic signed [QOUT_W-1:0] q
);

    localparam int ACC_W = acc_width(INTEGRAL_LIMIT);
    localparam int PP_W  = GAIN_W + 1 + POS_W;
    localparam int PI_W  = GAIN_W + 1 + ACC_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam logic signed [DIFF_W-1:0] LIM_HI = DIFF_W'(INTEGRAL_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [SUM_W-1:0]  PWM_HI = SUM_W'(PWM_MAX);
    localparam logic signed [SUM_W-1:0]  PWM_LO = -PWM_HI;
    localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

    // stage 1: error of the tick and per-axis loop state
    logic                     v1_reg;
    logic signed [POS_W-1:0]  e1_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [POS_W-1:0]  prior_reg;
    logic [CNT_W-1:0]         over_reg, over_next;

    logic signed [DIFF_W-1:0] acc_sum, acc_clamp, diff;
    logic signed [POS_W-1:0]  mfe_pos, mfe_neg;
    logic                     over_hit;

    // stage 2..5 payload
    logic signed [POS_W-1:0]  e2_reg;
    logic signed [ACC_W-1:0]  acc2_reg;
    logic signed [DIFF_W-1:0] d2_reg;
    logic signed [PP_W-1:0]   pp_reg, pp_next;
    logic signed [PI_W-1:0]   pi_reg, pi_next;
    logic signed [PD_W-1:0]   pd_reg, pd_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  qr_reg, qr_next;
    logic signed [SUM_W-1:0]  shifted;
    logic                     round_up;

    always_comb begin
        acc_sum = DIFF_W'(e1_reg) + DIFF_W'(acc_reg);
        if (acc_sum > LIM_HI) begin
            acc_clamp = LIM_HI;
        end else if (acc_sum < LIM_LO) begin
            acc_clamp = LIM_LO;
        end else begin
            acc_clamp = acc_sum;
        end
        acc_next = ACC_W'(acc_clamp);
        diff     = DIFF_W'(e1_reg) - DIFF_W'(prior_reg);

        mfe_pos  = $signed(POS_W'(limits.max_follow_error));
        mfe_neg  = -mfe_pos;
        over_hit = (e1_reg > mfe_pos) || (e1_reg < mfe_neg);
        if (!over_hit) begin
            over_next = '0;
        end else if (&over_reg) begin
            over_next = over_reg;
        end else begin
            over_next = over_reg + CNT_W'(1);
        end
        alarm_set = v1_reg && (over_next > limits.max_error_ticks);
    end

    always_comb begin
        pp_next  = $signed({1'b0, gains.prop_gain}) * e2_reg;
        pi_next  = $signed({1'b0, gains.integ_gain}) * acc2_reg;
        pd_next  = $signed({1'b0, gains.deriv_gain}) * d2_reg;
        sum_next = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
        // arithmetic shift rounds down, so nudge negatives with a fraction back up
        shifted  = sum_reg >>> GAIN_FRAC_BITS;
        round_up = sum_reg[SUM_W-1] && (|(sum_reg & FRAC_MASK));
        qr_next  = shifted + $signed(SUM_W'(round_up));
        if (qr_reg > PWM_HI) begin
            q = QOUT_W'(PWM_HI);
        end else if (qr_reg < PWM_LO) begin
            q = QOUT_W'(PWM_LO);
        end else begin
            q = QOUT_W'(qr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            acc_reg   <= '0;
            prior_reg <= '0;
            over_reg  <= '0;
        end else if (adv) begin
            v1_reg <= go;
            if (v1_reg) begin
                acc_reg   <= acc_next;
                prior_reg <= e1_reg;
                over_reg  <= over_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg   <= e_in;
            e2_reg   <= e1_reg;
            acc2_reg <= acc_next;
            d2_reg   <= diff;
            pp_reg   <= pp_next;
            pi_reg   <= pi_next;
            pd_reg   <= pd_next;
            sum_reg  <= sum_next;
            qr_reg   <= qr_next;
        end
    end

endmodule

[rtl/core/dasp_merge.sv]
// merge stage: tick control delay line matched to the lanes, duty split of both
// axes and the result output register; depends on dasp_pkg
module dasp_merge
    import dasp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tick_ctl_t                tick_in,
    input  logic signed [QOUT_W-1:0] q_x,
    input  logic signed [QOUT_W-1:0] q_y,
    output logic                     adv,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DUTY_W-1:0]        m_x_fwd_duty,
    output logic [DUTY_W-1:0]        m_x_rev_duty,
    output logic [DUTY_W-1:0]        m_y_fwd_duty,
    output logic [DUTY_W-1:0]        m_y_rev_duty,
    output logic                     m_driver_enable,
    output logic                     m_fault
);

    tick_ctl_t           ctl_reg [LANE_DEPTH];
    logic                m_valid_reg;
    logic [DUTY_W-1:0]   x_fwd_reg, x_rev_reg, y_fwd_reg, y_rev_reg;
    logic                enable_reg, fault_reg;
    logic [DUTY_W-1:0]   x_fwd_next, x_rev_next, y_fwd_next, y_rev_next;
    logic signed [QOUT_W-1:0] x_neg, y_neg;
    tick_ctl_t           head;

    assign head = ctl_reg[LANE_DEPTH-1];
    assign adv  = !m_valid_reg || m_ready;

    always_comb begin
        x_neg      = -q_x;
        y_neg      = -q_y;
        x_fwd_next = (q_x > 0) ? DUTY_W'(q_x) : '0;
        x_rev_next = (q_x < 0) ? DUTY_W'(x_neg) : '0;
        y_fwd_next = (q_y > 0) ? DUTY_W'(q_y) : '0;
        y_rev_next = (q_y < 0) ? DUTY_W'(y_neg) : '0;
        // alarmed tick drives nothing
        if (head.fault) begin
            x_fwd_next = '0;
            x_rev_next = '0;
            y_fwd_next = '0;
            y_rev_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANE_DEPTH; i++) begin
                ctl_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            ctl_reg[0] <= tick_in;
            for (int i = 1; i < LANE_DEPTH; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            m_valid_reg <= head.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && head.valid) begin
            x_fwd_reg  <= x_fwd_next;
            x_rev_reg  <= x_rev_next;
            y_fwd_reg  <= y_fwd_next;
            y_rev_reg  <= y_rev_next;
            enable_reg <= !head.fault;
            fault_reg  <= head.fault;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_x_fwd_duty    = x_fwd_reg;
    assign m_x_rev_duty    = x_rev_reg;
    assign m_y_fwd_duty    = y_fwd_reg;
    assign m_y_rev_duty    = y_rev_reg;
    assign m_driver_enable = enable_reg;
    assign m_fault         = fault_reg;

endmodule

[rtl/core/dual_axis_servo_pid_with_fault.sv]
// two-axis step/dir servo with pid loops and latched following-error alarm
// a tick request passes the lane stages and the result output register before it shows on the result channel
// throughput: one request per cycle; only the result output register stalls the pipeline
// step requests update the axis error in the accept cycle and produce no result
// reset (aresetn low, synchronous): positions, loop state and alarm cleared, gains and limits to defaults
module dual_axis_servo_pid_with_fault
    import dasp_pkg::*;
#(
    parameter int PWM_MAX        = PWM_MAX_DEF,
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic                 s_step_dir,
    input  logic [ENC_W-1:0]     s_enc_count_x,
    input  logic [ENC_W-1:0]     s_enc_count_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_W-1:0]    m_x_fwd_duty,
    output logic [DUTY_W-1:0]    m_x_rev_duty,
    output logic [DUTY_W-1:0]    m_y_fwd_duty,
    output logic [DUTY_W-1:0]    m_y_rev_duty,
    output logic                 m_driver_enable,
    output logic                 m_fault,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    gains_t  gains_x_reg, gains_y_reg;
    limits_t limits_reg;

    // error is kept as target minus position, so steps and encoder deltas both act on it
    logic signed [POS_W-1:0] err_x_reg, err_y_reg, err_x_next, err_y_next;
    logic [ENC_W-1:0]        last_x_reg, last_y_reg, dx, dy;
    logic                    alarm_reg, alarm_now;
    logic                    alarm_set_x, alarm_set_y;
    logic                    adv, accept, is_tick, go;
    logic signed [QOUT_W-1:0] q_x, q_y;
    tick_ctl_t               tick_in;

    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign is_tick   = (s_func == FUNC_TICK);
    assign alarm_now = alarm_reg || alarm_set_x || alarm_set_y;
    assign go        = accept && is_tick && !alarm_now;

    always_comb begin
        dx         = s_enc_count_x - last_x_reg;
        dy         = s_enc_count_y - last_y_reg;
        err_x_next = err_x_reg - POS_W'($signed(dx));
        err_y_next = err_y_reg - POS_W'($signed(dy));
        tick_in.valid = accept && is_tick;
        tick_in.fault = alarm_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_x_reg  <= '0;
            err_y_reg  <= '0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            alarm_reg  <= 1'b0;
        end else begin
            if (adv) begin
                alarm_reg <= alarm_now;
            end
            if (accept && s_func == FUNC_STEP_X) begin
                err_x_reg <= s_step_dir ? err_x_reg + POS_W'(1) : err_x_reg - POS_W'(1);
            end else if (accept && s_func == FUNC_STEP_Y) begin
                err_y_reg <= s_step_dir ? err_y_reg + POS_W'(1) : err_y_reg - POS_W'(1);
            end else if (go) begin
                err_x_reg  <= err_x_next;
                err_y_reg  <= err_y_next;
                last_x_reg <= s_enc_count_x;
                last_y_reg <= s_enc_count_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_x_reg <= '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST};
            gains_y_reg <= '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST};
            limits_reg  <= '{MAX_FOLLOW_RST, MAX_TICKS_RST};
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROP_X:     gains_x_reg.prop_gain       <= cfg_data;
                CFG_INTEG_X:    gains_x_reg.integ_gain      <= cfg_data;
                CFG_DERIV_X:    gains_x_reg.deriv_gain      <= cfg_data;
                CFG_PROP_Y:     gains_y_reg.prop_gain       <= cfg_data;
                CFG_INTEG_Y:    gains_y_reg.integ_gain      <= cfg_data;
                CFG_DERIV_Y:    gains_y_reg.deriv_gain      <= cfg_data;
                CFG_MAX_FOLLOW: limits_reg.max_follow_error <= cfg_data;
                CFG_MAX_TICKS:  limits_reg.max_error_ticks  <= cfg_data;
                default: ;
            endcase
        end
    end

    dasp_lane #(
        .PWM_MAX        (PWM_MAX),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .go        (go),
        .e_in      (err_x_next),
        .gains     (gains_x_reg),
        .limits    (limits_reg),
        .alarm_set (alarm_set_x),
        .q         (q_x)
    );

    dasp_lane #(
        .PWM_MAX        (PWM_MAX),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .go        (go),
        .e_in      (err_y_next),
        .gains     (gains_y_reg),
        .limits    (limits_reg),
        .alarm_set (alarm_set_y),
        .q         (q_y)
    );

    dasp_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_in         (tick_in),
        .q_x             (q_x),
        .q_y             (q_y),
        .adv             (adv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_fwd_duty    (m_x_fwd_duty),
        .m_x_rev_duty    (m_x_rev_duty),
        .m_y_fwd_duty    (m_y_fwd_duty),
        .m_y_rev_duty    (m_y_rev_duty),
        .m_driver_enable (m_driver_enable),
        .m_fault         (m_fault)
    );

endmodule
